### rtl/core/byte_stack_burst_drain_unit_assert.svh
// Assertion macros for the byte stack burst drain unit.
// Included by the top level; no other dependencies.
`ifndef BYTE_STACK_BURST_DRAIN_UNIT_ASSERT_SVH
`define BYTE_STACK_BURST_DRAIN_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define BSBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsbd: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define BSBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsbd: next-cycle check failed");
`else
`define BSBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BSBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/bsbd_pkg.sv
// Shared types and constants of the byte stack burst drain unit.
// No dependencies.
package bsbd_pkg;

    localparam int SIZE_W = 7;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [SIZE_W-1:0] DRAIN_RESET = 7'd50;
    localparam logic [SIZE_W-1:0] DRAIN_MAX   = 7'd64;

    // Control from the sequencer to the store.
    typedef struct packed {
        logic              push;
        logic [7:0]        push_data;
        logic              drain;
        logic [SIZE_W-1:0] size;
        logic              rd_en;
    } t_store_ctl;

    // Status from the store back to the sequencer.
    typedef struct packed {
        logic       can_drain;
        logic [7:0] rd_data;
    } t_store_sts;

endpackage

### rtl/core/bsbd_in_if.sv
// Input channel of the byte stack burst drain unit: command and byte.
// No dependencies.
interface bsbd_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_in;

    modport source (output valid, output cmd, output data_in, input ready);
    modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

### rtl/core/bsbd_out_if.sv
// Output channel of the byte stack burst drain unit: popped byte and last flag.
// No dependencies.
interface bsbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       last;

    modport source (output valid, output data_out, output last, input ready);
    modport sink   (input valid, input data_out, input last, output ready);
endinterface

### rtl/core/bsbd_store.sv
// Byte store of the stack: memory array, fill count and pop pointer.
// Depends on bsbd_pkg.
module bsbd_store
    import bsbd_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_ctl i_ctl,
    output t_store_sts o_sts
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [7:0]    r_mem [DEPTH];
    logic [CW-1:0] r_fill;
    logic [AW-1:0] r_ptr;
    logic [7:0]    r_rd_data;

    logic          push_ok;
    logic [CW-1:0] size_ext;

    assign push_ok  = i_ctl.push && (r_fill < CW'(DEPTH));
    assign size_ext = CW'(i_ctl.size);

    assign o_sts.can_drain = (i_ctl.size != '0) && (r_fill >= size_ext);
    assign o_sts.rd_data   = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (push_ok) begin
            r_fill <= r_fill + CW'(1);
        end else if (i_ctl.drain) begin
            r_fill <= r_fill - size_ext;
        end
    end

    // Pop pointer: load with top of stack on a drain, walk down per read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.drain) begin
            r_ptr <= AW'(r_fill - CW'(1));
        end else if (i_ctl.rd_en) begin
            r_ptr <= r_ptr - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_fill[AW-1:0]] <= i_ctl.push_data;
        end
    end

    // Registered read port; holds its data when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

endmodule

### rtl/core/byte_stack_burst_drain_unit.sv
// Byte stack burst drain unit: LIFO byte store emptied in fixed-size bursts.
// Depends on bsbd_pkg, bsbd_in_if, bsbd_out_if, bsbd_store and the assertion header.
//
// Usage:
//   i_in carries one beat per command: cmd = push stores data_in on top of the
//   stack (dropped when full), cmd = drain pops drain_size bytes newest first
//   if at least that many are held, else does nothing.
//   o_out carries one beat per popped byte; last marks the final byte of a burst.
//   i_cfg_we / i_cfg_wdata write drain_size (values above 64 act as 64, zero
//   pops nothing). Write it only while the unit is idle.
// Timing:
//   A push is taken whenever the unit is idle; pushes are taken back to back.
//   A drain of N bytes holds the input until all N are read, one read of the
//   single memory port per byte. Each byte passes the memory read register and
//   the output register to o_out; one byte per cycle while o_out is not stalled.
// Reset:
//   Clears the fill count, the sequencer and the output stage; drain_size
//   returns to 50. The memory itself is not cleared.
// Stall:
//   A two-stage pipe (memory read register, output register) holds data while
//   o_out.ready is low; reads pause and resume without loss.
`include "byte_stack_burst_drain_unit_assert.svh"

module byte_stack_burst_drain_unit
    import bsbd_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    bsbd_in_if.sink           i_in,
    bsbd_out_if.source        o_out
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    t_state            r_state;
    logic [SIZE_W-1:0] r_drain_size;
    logic [SIZE_W-1:0] r_left;
    logic              r_rd_v;
    logic              r_rd_last;
    logic              r_out_v;
    logic [7:0]        r_out_data;
    logic              r_out_last;

    logic [SIZE_W-1:0] size_eff;
    logic              in_fire;
    logic              drain_go;
    logic              out_free;
    logic              rd_issue;
    logic              rd_move;
    t_store_ctl        store_ctl;
    t_store_sts        store_sts;

    // Clamp the burst size to the largest supported burst.
    assign size_eff = (r_drain_size > DRAIN_MAX) ? DRAIN_MAX : r_drain_size;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign drain_go   = in_fire && (i_in.cmd == CMD_DRAIN) && store_sts.can_drain;

    // Output register is free when empty or being taken this cycle.
    assign out_free = !r_out_v || o_out.ready;
    // Issue a read when the read register is empty or moves on this cycle.
    assign rd_issue = (r_state == ST_DRAIN) && (!r_rd_v || out_free);
    assign rd_move  = r_rd_v && out_free;

    assign store_ctl.push      = in_fire && (i_in.cmd == CMD_PUSH);
    assign store_ctl.push_data = i_in.data_in;
    assign store_ctl.drain     = drain_go;
    assign store_ctl.size      = size_eff;
    assign store_ctl.rd_en     = rd_issue;

    bsbd_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (store_ctl),
        .o_sts   (store_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain_size <= DRAIN_RESET;
        end else if (i_cfg_we) begin
            r_drain_size <= i_cfg_wdata;
        end
    end

    // Sequencer: state, burst counter and the valid bits of both pipe stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_left  <= '0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (drain_go) begin
                        r_state <= ST_DRAIN;
                        r_left  <= size_eff;
                    end
                end
                ST_DRAIN: begin
                    if (rd_issue) begin
                        r_left <= r_left - SIZE_W'(1);
                        if (r_left == SIZE_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (rd_issue) begin
                r_rd_v <= 1'b1;
            end else if (rd_move) begin
                r_rd_v <= 1'b0;
            end

            if (rd_move) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload of the pipe stages; held while stalled.
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_last <= (r_left == SIZE_W'(1));
        end
        if (rd_move) begin
            r_out_data <= store_sts.rd_data;
            r_out_last <= r_rd_last;
        end
    end

    assign o_out.valid    = r_out_v;
    assign o_out.data_out = r_out_data;
    assign o_out.last     = r_out_last;

    `BSBD_ASSERT_IMP(a_busy_has_bytes, i_clk, i_rst_n, r_state == ST_DRAIN, r_left != '0)
    `BSBD_ASSERT_NXT(a_drain_loads_count, i_clk, i_rst_n, drain_go,
                     r_state == ST_DRAIN && r_left == $past(size_eff))
    `BSBD_ASSERT_NXT(a_final_read_ends, i_clk, i_rst_n, rd_issue && r_left == SIZE_W'(1),
                     r_state == ST_IDLE && r_rd_v && r_rd_last)

endmodule

### sim/bsbd_stack_checker.sv
// Scoreboard for the byte stack burst drain unit: mirrors the LIFO store,
// predicts every popped byte and compares it with the output channel.
// Depends on bsbd_pkg, bsbd_in_if and bsbd_out_if.
`timescale 1ns / 1ps

module bsbd_stack_checker
    import bsbd_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  logic              i_final_check,
    bsbd_in_if                i_in_mon,
    bsbd_out_if               i_out_mon,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_push_count,
    output int                o_drop_count,
    output int                o_drain_count,
    output int                o_burst_count,
    output int                o_pop_count
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_popped_byte;

    logic [7:0]        stack_mem [DEPTH];
    int unsigned       stack_fill;
    logic [SIZE_W-1:0] burst_cfg;
    t_popped_byte      popped_q [$];

    int fail_cnt = 0;
    int pushes   = 0;
    int drops    = 0;
    int drains   = 0;
    int bursts   = 0;
    int pops     = 0;

    task automatic note_failure(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_popped_byte want;
        t_popped_byte nxt;
        int unsigned  n;
        if (!i_rst_n) begin
            stack_fill = 0;
            burst_cfg  = DRAIN_RESET;
            popped_q.delete();
        end else begin
            // Compare the output beat first: it always belongs to an older drain.
            if (i_out_mon.valid && i_out_mon.ready) begin
                pops++;
                if (popped_q.size() == 0) begin
                    note_failure($sformatf("byte %02h popped with nothing pending",
                                           i_out_mon.data_out));
                end else begin
                    want = popped_q.pop_front();
                    if (i_out_mon.data_out !== want.data) begin
                        note_failure($sformatf("data_out %02h, expected %02h",
                                               i_out_mon.data_out, want.data));
                    end
                    if (i_out_mon.last !== want.last) begin
                        note_failure($sformatf("last %b, expected %b on byte %02h",
                                               i_out_mon.last, want.last, want.data));
                    end
                end
            end

            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.cmd == CMD_PUSH) begin
                    // Drop silently once the store is full.
                    if (stack_fill < DEPTH) begin
                        stack_mem[stack_fill] = i_in_mon.data_in;
                        stack_fill++;
                        pushes++;
                    end else begin
                        drops++;
                    end
                end else begin
                    drains++;
                    n = (burst_cfg > DRAIN_MAX) ? DRAIN_MAX : burst_cfg;
                    if (n != 0 && stack_fill >= n) begin
                        for (int k = 0; k < n; k++) begin
                            nxt.data = stack_mem[stack_fill - 1 - k];
                            nxt.last = (k == n - 1);
                            popped_q.push_back(nxt);
                        end
                        stack_fill -= n;
                        bursts++;
                    end
                end
            end

            // A write at this edge applies to beats after it.
            if (i_cfg_we) begin
                burst_cfg = i_cfg_wdata;
            end

            if (i_final_check && popped_q.size() != 0) begin
                note_failure($sformatf("%0d popped bytes never arrived", popped_q.size()));
                popped_q.delete();
            end
        end

        o_fail_count  <= fail_cnt;
        o_pending     <= popped_q.size();
        o_push_count  <= pushes;
        o_drop_count  <= drops;
        o_drain_count <= drains;
        o_burst_count <= bursts;
        o_pop_count   <= pops;
    end

endmodule

### sim/byte_stack_burst_drain_unit_tb.sv
// Testbench top of the byte stack burst drain unit: clock, reset, push and
// drain stimulus, receiver back-pressure and the final verdict.
// Depends on bsbd_pkg, bsbd_in_if, bsbd_out_if, bsbd_stack_checker and the unit.
`timescale 1ns / 1ps

module byte_stack_burst_drain_unit_tb;
    import bsbd_pkg::*;

    localparam int STACK_DEPTH   = 256;
    localparam int SETTLE_CYCLES = 8;     // covers a drain that pops nothing
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int END_LIMIT     = 20000; // cycles allowed for the last bursts

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;
    logic              final_chk;

    // Knobs shared between the sender and the receiver processes.
    bit tail_mode         = 1'b0;
    bit long_hold_pending = 1'b0;

    int fail_count;
    int pending;
    int push_count;
    int drop_count;
    int drain_count;
    int burst_count;
    int pop_count;

    bsbd_in_if  in_ch ();
    bsbd_out_if out_ch ();

    byte_stack_burst_drain_unit #(
        .DEPTH (STACK_DEPTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    bsbd_stack_checker #(
        .DEPTH (STACK_DEPTH)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_final_check (final_chk),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_push_count  (push_count),
        .o_drop_count  (drop_count),
        .o_drain_count (drain_count),
        .o_burst_count (burst_count),
        .o_pop_count   (pop_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: every iteration makes exactly one assignment to ready and then
    // advances at least one edge, so ready never gets two updates in a step.
    initial begin
        forever begin
            if (long_hold_pending) begin
                // Hold off long enough for a drain to back up into the input.
                long_hold_pending = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (!tail_mode && $urandom_range(0, 99) < 15) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Offer one beat and return at the edge that accepts it. Valid is left high
    // so that a following beat goes out back to back.
    task automatic send_beat(input logic cmd, input logic [7:0] value);
        if (!tail_mode && $urandom_range(0, 99) < 20) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= cmd;
        in_ch.data_in <= value;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // Pause the sender until every predicted byte has come out, then let the
    // unit finish any drain that pops nothing.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write drain_size only while the unit is idle.
    task automatic set_drain_size(input logic [SIZE_W-1:0] size);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random mix of pushes and drains; drains carry random (ignored) bytes too.
    task automatic run_mix(input int count, input int push_pct);
        logic cmd;
        for (int i = 0; i < count; i++) begin
            cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_DRAIN;
            send_beat(cmd, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int waited;

        // Known values on every input from time zero; reset is held low first.
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        final_chk     <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.cmd     <= CMD_PUSH;
        in_ch.data_in <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset drain size of 50, drain on an empty stack, the byte
        // extremes, and a drain that stays below the threshold.
        send_beat(CMD_DRAIN, 8'hFF);
        send_beat(CMD_PUSH,  8'h00);
        send_beat(CMD_PUSH,  8'hFF);
        send_beat(CMD_PUSH,  8'hAA);
        send_beat(CMD_PUSH,  8'h55);
        send_beat(CMD_DRAIN, 8'h00);

        // Smallest burst: a single byte that is also the last one.
        set_drain_size(7'd1);
        send_beat(CMD_DRAIN, 8'h5A);
        send_beat(CMD_PUSH,  8'hFF);
        send_beat(CMD_DRAIN, 8'hA5);

        // Size zero pops nothing, however many bytes are held.
        set_drain_size(7'd0);
        send_beat(CMD_PUSH,  8'h80);
        send_beat(CMD_DRAIN, 8'h01);

        // Largest register value acts as 64: too few bytes held, no burst.
        set_drain_size(7'h7F);
        send_beat(CMD_DRAIN, 8'hFE);

        // Two-byte bursts until the stack runs below the threshold.
        set_drain_size(7'd2);
        send_beat(CMD_DRAIN, 8'h7F);
        send_beat(CMD_DRAIN, 8'h00);
        send_beat(CMD_DRAIN, 8'hFF);

        // Random part: short bursts first.
        set_drain_size(7'd3);
        run_mix(20, 60);
        set_drain_size(7'd1);
        run_mix(12, 50);

        // Receiver holds off while pushes and drains keep coming, so the
        // output pipe fills and the drain backs up into the input.
        set_drain_size(7'd5);
        long_hold_pending = 1'b1;
        run_mix(25, 75);

        // Size zero again, pushes only: overflow the store and drop bytes.
        set_drain_size(7'd0);
        run_mix(262, 100);

        // Empty the full stack in large bursts.
        set_drain_size(DRAIN_RESET);
        run_mix(10, 30);
        set_drain_size(7'd65);
        run_mix(10, 30);

        // Last stretch without any idling on either side.
        set_drain_size(DRAIN_MAX);
        tail_mode = 1'b1;
        run_mix(10, 50);

        // Drop valid, wait for the last bursts with a bound, then flush the
        // scoreboard so that leftovers count as failures.
        in_ch.valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < END_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        final_chk <= 1'b1;
        @(posedge clk);
        final_chk <= 1'b0;
        @(posedge clk);

        $display("Run covered %0d stored pushes, %0d pushes dropped on a full stack,",
                 push_count, drop_count);
        $display("%0d drains with %0d bursts and %0d popped bytes, drain sizes 0 to 127.",
                 drain_count, burst_count, pop_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
